// File: hdl/tes_pkg.sv
// Shared types and constants for the text encoding sniffer.
package tes_pkg;

    // Widths of the byte path and of the sample counter.
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LIMIT_W = 21;

    // Largest sample and the sample size after reset.
    localparam logic [LIMIT_W-1:0] MAX_SAMPLE   = LIMIT_W'(1024 * 1024);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET  = LIMIT_W'(1024);
    localparam logic [LIMIT_W-1:0] LIMIT_ONE    = LIMIT_W'(1);

    // Verdict codes.
    typedef enum logic [1:0] {
        ENC_EUC_JP = 2'd0,
        ENC_UTF8   = 2'd1,
        ENC_MIXED  = 2'd2
    } t_enc;

    // One byte of the buffer as held in the input register.
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] byte_value;
        logic              last_byte;
    } t_item;

    // One verdict.
    typedef struct packed {
        t_enc encoding;
        logic all_ascii;
        logic utf8_valid;
        logic euc_valid;
    } t_verdict;

endpackage

// File: hdl/tes_in_reg.sv
// Input register that holds one byte transfer until the classifier takes it.
module tes_in_reg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [tes_pkg::BYTE_W-1:0]    i_byte_value,
    input  logic                          i_last_byte,
    input  logic                          i_take,
    output tes_pkg::t_item                o_item
);

    logic                       r_valid;
    logic [tes_pkg::BYTE_W-1:0] r_byte;
    logic                       r_last;

    // The register is free when empty or when its byte moves on this cycle.
    assign o_in_stall = r_valid && !i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_valid <= i_in_valid;
        end
        if (!o_in_stall && i_in_valid) begin
            r_byte <= i_byte_value;
            r_last <= i_last_byte;
        end
    end

    assign o_item = '{valid: r_valid, byte_value: r_byte, last_byte: r_last};

endmodule

// File: hdl/tes_classify.sv
// Per-buffer classification state and the checks applied to each byte.
module tes_classify (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tes_pkg::t_item                i_item,
    input  logic                          i_take,
    input  logic [tes_pkg::LIMIT_W-1:0]   i_limit,
    output logic                          o_emit,
    output tes_pkg::t_verdict             o_verdict
);

    logic [tes_pkg::LIMIT_W-1:0] r_count, n_count;
    logic [1:0]                  r_u_pend, n_u_pend;
    logic                        r_u_ok, n_u_ok;
    logic                        r_e_pend, n_e_pend;
    logic                        r_e_ok, n_e_ok;
    logic                        r_ascii, n_ascii;
    logic                        r_sent, n_sent;

    logic [tes_pkg::LIMIT_W-1:0] lim;
    logic                        in_sample;
    logic [tes_pkg::BYTE_W-1:0]  b;
    logic                        sample_done;
    logic                        all_failed;
    logic                        emit;

    assign b = i_item.byte_value;

    // Clamp the sample size into its legal range.
    always_comb begin
        lim = i_limit;
        if (i_limit == '0) begin
            lim = tes_pkg::LIMIT_ONE;
        end else if (i_limit > tes_pkg::MAX_SAMPLE) begin
            lim = tes_pkg::MAX_SAMPLE;
        end
    end

    assign in_sample = r_count < lim;

    // Checks for one byte, then the end-of-buffer and verdict decisions.
    always_comb begin
        n_count  = r_count;
        n_u_pend = r_u_pend;
        n_u_ok   = r_u_ok;
        n_e_pend = r_e_pend;
        n_e_ok   = r_e_ok;
        n_ascii  = r_ascii;

        // UTF-8 shape: leads open a sequence, continuations close it.
        if (r_u_ok) begin
            if (r_u_pend != 2'd0) begin
                if (b[7:6] != 2'b10) begin
                    n_u_ok   = 1'b0;
                    n_u_pend = 2'd0;
                end else begin
                    n_u_pend = r_u_pend - 2'd1;
                end
            end else if (in_sample && b[7]) begin
                if (b[7:5] == 3'b110) begin
                    n_u_pend = 2'd1;
                end else if (b[7:4] == 4'b1110) begin
                    n_u_pend = 2'd2;
                end else if (b[7:3] == 5'b11110) begin
                    n_u_pend = 2'd3;
                end else begin
                    n_u_ok = 1'b0;
                end
            end
        end

        // EUC pairs: a high byte must be followed by another high byte.
        if (r_e_ok) begin
            if (r_e_pend) begin
                n_e_pend = 1'b0;
                if (!b[7]) begin
                    n_e_ok = 1'b0;
                end
            end else if (in_sample && b[7]) begin
                n_e_pend = 1'b1;
            end
        end

        if (in_sample) begin
            if (b[7]) begin
                n_ascii = 1'b0;
            end
            n_count = r_count + tes_pkg::LIMIT_ONE;
        end

        // A sequence still open at the end of the buffer fails its check.
        if (i_item.last_byte) begin
            if (n_u_pend != 2'd0) begin
                n_u_ok   = 1'b0;
                n_u_pend = 2'd0;
            end
            if (n_e_pend) begin
                n_e_ok   = 1'b0;
                n_e_pend = 1'b0;
            end
        end
    end

    assign sample_done = (n_count >= lim) && (n_u_pend == 2'd0) && !n_e_pend;
    assign all_failed  = !n_ascii && !n_u_ok && !n_e_ok;
    assign emit        = !r_sent && (i_item.last_byte || sample_done || all_failed);
    assign o_emit      = emit;

    // Verdict priority: ASCII, then UTF-8, then EUC-JP, else mixed.
    always_comb begin
        o_verdict.all_ascii  = n_ascii;
        o_verdict.utf8_valid = n_u_ok;
        o_verdict.euc_valid  = n_e_ok;
        if (n_ascii) begin
            o_verdict.encoding = tes_pkg::ENC_EUC_JP;
        end else if (n_u_ok) begin
            o_verdict.encoding = tes_pkg::ENC_UTF8;
        end else if (n_e_ok) begin
            o_verdict.encoding = tes_pkg::ENC_EUC_JP;
        end else begin
            o_verdict.encoding = tes_pkg::ENC_MIXED;
        end
    end

    assign n_sent = emit;

    // State moves only when a byte is taken; the last byte clears it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_item.last_byte)) begin
            r_count  <= '0;
            r_u_pend <= 2'd0;
            r_u_ok   <= 1'b1;
            r_e_pend <= 1'b0;
            r_e_ok   <= 1'b1;
            r_ascii  <= 1'b1;
            r_sent   <= 1'b0;
        end else if (i_take && !r_sent) begin
            r_count  <= n_count;
            r_u_pend <= n_u_pend;
            r_u_ok   <= n_u_ok;
            r_e_pend <= n_e_pend;
            r_e_ok   <= n_e_ok;
            r_ascii  <= n_ascii;
            r_sent   <= n_sent;
        end
    end

endmodule

// File: hdl/text_encoding_sniffer_core.sv
// Top level of the text encoding sniffer: config register, stages and result register.
//
//  Channel  | Signals                                        | Moves
//  ---------+------------------------------------------------+-------------------------
//  in       | i_in_valid, o_in_stall, i_byte_value, i_last_byte | one byte per transfer
//  out      | o_out_valid, i_out_stall, o_encoding, o_all_ascii, | one verdict per buffer
//           | o_utf8_valid, o_euc_valid                      |
//  cfg      | i_cfg_we, i_cfg_data                           | sample_limit write
//
// A byte is held in the input register and is classified on its way into the
// result register, which holds the verdict that the deciding byte produces.
// One byte is accepted every cycle while the result register can move.
// Reset is synchronous and active low; the sample limit returns to 1024.
// A stall on the result side holds the verdict and, once the input register is full,
// stalls the input side in the same cycle.
module text_encoding_sniffer_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [tes_pkg::BYTE_W-1:0]    i_byte_value,
    input  logic                          i_last_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_encoding,
    output logic                          o_all_ascii,
    output logic                          o_utf8_valid,
    output logic                          o_euc_valid,
    input  logic                          i_cfg_we,
    input  logic [tes_pkg::LIMIT_W-1:0]   i_cfg_data
);

    logic [tes_pkg::LIMIT_W-1:0] r_limit;
    logic                        r_out_valid;
    tes_pkg::t_verdict           r_verdict;

    tes_pkg::t_item              item;
    tes_pkg::t_verdict           verdict;
    logic                        emit;
    logic                        out_free;
    logic                        take;

    // The result register can load when empty or when its verdict transfers now.
    assign out_free = !r_out_valid || !i_out_stall;
    assign take     = item.valid && out_free;

    // Sample limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= tes_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_data;
        end
    end

    tes_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_byte_value (i_byte_value),
        .i_last_byte  (i_last_byte),
        .i_take       (take),
        .o_item       (item)
    );

    tes_classify u_classify (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (item),
        .i_take    (take),
        .i_limit   (r_limit),
        .o_emit    (emit),
        .o_verdict (verdict)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= take && emit;
        end
        if (out_free && take && emit) begin
            r_verdict <= verdict;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_encoding   = r_verdict.encoding;
    assign o_all_ascii  = r_verdict.all_ascii;
    assign o_utf8_valid = r_verdict.utf8_valid;
    assign o_euc_valid  = r_verdict.euc_valid;

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the text encoding sniffer: directed table, then random buffers.
module testbench;
    import tes_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_BYTES = 1000;
    localparam int DRAIN_CYCLES = 6;

    // Row kinds and check kinds of the directed table.
    localparam logic [1:0] ROW_BYTE  = 2'd0;
    localparam logic [1:0] ROW_LIMIT = 2'd1;
    localparam logic [1:0] CHK_MODEL = 2'd0;
    localparam logic [1:0] CHK_NONE  = 2'd1;
    localparam logic [1:0] CHK_GIVEN = 2'd2;

    // Segment kinds used to build random buffers.
    localparam int SEG_ASCII = 0;
    localparam int SEG_UTF8  = 1;
    localparam int SEG_EUC   = 2;
    localparam int SEG_NOISE = 3;

    // Verdicts that can be read straight off the rules.
    localparam t_verdict V_ASCII = '{ENC_EUC_JP, 1'b1, 1'b1, 1'b1};
    localparam t_verdict V_MIXED = '{ENC_MIXED, 1'b0, 1'b0, 1'b0};
    localparam t_verdict V_EUC   = '{ENC_EUC_JP, 1'b0, 1'b0, 1'b1};
    localparam t_verdict V_NONE  = '{ENC_EUC_JP, 1'b0, 1'b0, 1'b0};

    typedef struct packed {
        logic [1:0]         kind;
        logic [LIMIT_W-1:0] value;
        logic               last;
        logic [1:0]         chk;
        t_verdict           want;
    } dir_row_t;

    localparam int DIR_ROWS = 28;
    localparam dir_row_t DIR_TABLE [0:DIR_ROWS-1] = '{
        // Plain ASCII right after reset, then the byte extremes.
        '{ROW_BYTE,  21'h041, 1'b1, CHK_GIVEN, V_ASCII},
        '{ROW_BYTE,  21'h000, 1'b0, CHK_MODEL, V_NONE},
        '{ROW_BYTE,  21'h07f, 1'b1, CHK_GIVEN, V_ASCII},
        // Two-byte and four-byte UTF-8 sequences.
        '{ROW_BYTE,  21'h0c3, 1'b0, CHK_MODEL, V_NONE},
        '{ROW_BYTE,  21'h0a9, 1'b1, CHK_MODEL, V_NONE},
        '{ROW_BYTE,  21'h0f0, 1'b0, CHK_MODEL, V_NONE},
        '{ROW_BYTE,  21'h09f, 1'b0, CHK_MODEL, V_NONE},
        '{ROW_BYTE,  21'h098, 1'b0, CHK_MODEL, V_NONE},
        '{ROW_BYTE,  21'h080, 1'b1, CHK_MODEL, V_NONE},
        // A lone 0xff fails every check.
        '{ROW_BYTE,  21'h0ff, 1'b1, CHK_GIVEN, V_MIXED},
        // Both checks fail early; the byte after the verdict gives nothing.
        '{ROW_BYTE,  21'h080, 1'b0, CHK_MODEL, V_NONE},
        '{ROW_BYTE,  21'h041, 1'b0, CHK_GIVEN, V_MIXED},
        '{ROW_BYTE,  21'h042, 1'b1, CHK_NONE,  V_NONE},
        // Buffer ends inside a UTF-8 sequence.
        '{ROW_BYTE,  21'h0e3, 1'b0, CHK_MODEL, V_NONE},
        '{ROW_BYTE,  21'h081, 1'b1, CHK_GIVEN, V_EUC},
        // A limit of zero behaves as one.
        '{ROW_LIMIT, 21'h000, 1'b0, CHK_NONE,  V_NONE},
        '{ROW_BYTE,  21'h041, 1'b0, CHK_GIVEN, V_ASCII},
        '{ROW_BYTE,  21'h0c3, 1'b1, CHK_NONE,  V_NONE},
        // A sequence that starts in the sample finishes beyond it.
        '{ROW_LIMIT, 21'h001, 1'b0, CHK_NONE,  V_NONE},
        '{ROW_BYTE,  21'h0e2, 1'b0, CHK_MODEL, V_NONE},
        '{ROW_BYTE,  21'h082, 1'b0, CHK_MODEL, V_NONE},
        '{ROW_BYTE,  21'h0ac, 1'b1, CHK_MODEL, V_NONE},
        // Limit above the maximum, then lowered below the count mid-buffer.
        '{ROW_LIMIT, 21'h1fffff, 1'b0, CHK_NONE, V_NONE},
        '{ROW_BYTE,  21'h041, 1'b0, CHK_MODEL, V_NONE},
        '{ROW_BYTE,  21'h042, 1'b0, CHK_MODEL, V_NONE},
        '{ROW_BYTE,  21'h043, 1'b0, CHK_MODEL, V_NONE},
        '{ROW_LIMIT, 21'h002, 1'b0, CHK_NONE,  V_NONE},
        '{ROW_BYTE,  21'h044, 1'b1, CHK_GIVEN, V_ASCII}
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic [BYTE_W-1:0]  in_byte = '0;
    logic               in_last = 1'b0;
    logic               out_stall = 1'b0;
    logic               cfg_we = 1'b0;
    logic [LIMIT_W-1:0] cfg_data = '0;
    logic               in_stall;
    logic               out_valid;
    logic [1:0]         out_encoding;
    logic               out_all_ascii;
    logic               out_utf8_valid;
    logic               out_euc_valid;

    // Predicted buffer state and the sample limit as last written.
    logic [LIMIT_W-1:0] limit_cfg = LIMIT_RESET;
    logic [LIMIT_W-1:0] seen_count = '0;
    logic [1:0]         utf8_left = '0;
    logic               utf8_good = 1'b1;
    logic               euc_open = 1'b0;
    logic               euc_good = 1'b1;
    logic               ascii_seen = 1'b1;
    logic               verdict_done = 1'b0;

    t_verdict    verdicts_due [$];
    logic [7:0]  buf_bytes [$];
    int          errors = 0;
    int          cycle_count = 0;
    int          stall_hold = 0;
    bit          tx_quiet = 1'b0;
    bit          rx_quiet = 1'b0;

    text_encoding_sniffer_core DUT (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_byte_value (in_byte),
        .i_last_byte  (in_last),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_encoding   (out_encoding),
        .o_all_ascii  (out_all_ascii),
        .o_utf8_valid (out_utf8_valid),
        .o_euc_valid  (out_euc_valid),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    // Watchdog on the total run length.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side stalls in bursts, mostly short, now and then long.
    always @(posedge clk) begin
        if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
        end else if (rx_quiet || $urandom_range(0, 2) != 0) begin
            out_stall  <= 1'b0;
            stall_hold <= $urandom_range(0, 6);
        end else begin
            out_stall  <= 1'b1;
            stall_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(0, 3);
        end
    end

    // Reports one field of a verdict that disagrees with the prediction.
    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // Files a predicted verdict behind the ones already waiting.
    function automatic void queue_verdict(input t_verdict v);
        verdicts_due = {verdicts_due, v};
    endfunction

    // Appends one byte to the buffer under construction.
    function automatic void add_byte(input logic [7:0] b);
        buf_bytes = {buf_bytes, b};
    endfunction

    // Every verdict transfer is checked against the oldest pending prediction.
    always @(posedge clk) begin
        t_verdict want;
        if (rst_n && out_valid && !out_stall) begin
            if (verdicts_due.size() == 0) begin
                $display("%0t: unexpected verdict, expected none, actual enc %0d flags %b%b%b",
                         $time, out_encoding, out_all_ascii, out_utf8_valid, out_euc_valid);
                errors++;
            end else begin
                want = verdicts_due.pop_front();
                check_field("encoding", want.encoding, out_encoding);
                check_field("all_ascii", want.all_ascii, out_all_ascii);
                check_field("utf8_valid", want.utf8_valid, out_utf8_valid);
                check_field("euc_valid", want.euc_valid, out_euc_valid);
            end
        end
    end

    // Classifies one byte and tells whether it completes the buffer's verdict.
    task automatic sniff_byte(input logic [7:0] b, input logic last,
                              output logic hit, output t_verdict v);
        logic [LIMIT_W-1:0] lim;
        logic               in_sample;
        logic               sample_done;
        logic               all_failed;
        hit = 1'b0;
        v   = V_NONE;
        lim = limit_cfg;
        if (lim == '0) lim = LIMIT_ONE;
        if (lim > MAX_SAMPLE) lim = MAX_SAMPLE;
        in_sample = seen_count < lim;
        if (!verdict_done) begin
            // UTF-8 lead and continuation shape.
            if (utf8_good) begin
                if (utf8_left != 2'd0) begin
                    if (b[7:6] != 2'b10) begin
                        utf8_good = 1'b0;
                        utf8_left = 2'd0;
                    end else begin
                        utf8_left = utf8_left - 2'd1;
                    end
                end else if (in_sample && b[7]) begin
                    if (b[7:5] == 3'b110) utf8_left = 2'd1;
                    else if (b[7:4] == 4'b1110) utf8_left = 2'd2;
                    else if (b[7:3] == 5'b11110) utf8_left = 2'd3;
                    else utf8_good = 1'b0;
                end
            end
            // EUC high-byte pairs.
            if (euc_good) begin
                if (euc_open) begin
                    euc_open = 1'b0;
                    if (!b[7]) euc_good = 1'b0;
                end else if (in_sample && b[7]) begin
                    euc_open = 1'b1;
                end
            end
            if (in_sample) begin
                if (b[7]) ascii_seen = 1'b0;
                seen_count = seen_count + 1'b1;
            end
            // A sequence still open at the end of the buffer fails its check.
            if (last) begin
                if (utf8_left != 2'd0) begin
                    utf8_good = 1'b0;
                    utf8_left = 2'd0;
                end
                if (euc_open) begin
                    euc_good = 1'b0;
                    euc_open = 1'b0;
                end
            end
            sample_done = seen_count >= lim && utf8_left == 2'd0 && !euc_open;
            all_failed  = !ascii_seen && !utf8_good && !euc_good;
            if (last || sample_done || all_failed) begin
                if (ascii_seen) v.encoding = ENC_EUC_JP;
                else if (utf8_good) v.encoding = ENC_UTF8;
                else if (euc_good) v.encoding = ENC_EUC_JP;
                else v.encoding = ENC_MIXED;
                v.all_ascii  = ascii_seen;
                v.utf8_valid = utf8_good;
                v.euc_valid  = euc_good;
                verdict_done = 1'b1;
                hit = 1'b1;
            end
        end
        if (last) begin
            seen_count   = '0;
            utf8_left    = 2'd0;
            utf8_good    = 1'b1;
            euc_open     = 1'b0;
            euc_good     = 1'b1;
            ascii_seen   = 1'b1;
            verdict_done = 1'b0;
        end
    endtask

    // Idle cycles before a byte: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_quiet || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offers one byte and returns once its transfer has happened.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        in_last  <= last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Sends a byte and files the verdict it is predicted to produce.
    task automatic feed_byte(input logic [7:0] b, input logic last);
        logic     hit;
        t_verdict v;
        send_byte(b, last);
        sniff_byte(b, last, hit, v);
        if (hit) queue_verdict(v);
    endtask

    // Waits until every predicted verdict has arrived and the pipeline is empty.
    task automatic drain();
        in_valid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        cfg_data <= value;
        cfg_we   <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        limit_cfg  = value;
    endtask

    // Mostly small limits so that early verdicts are frequent; extremes now and then.
    function automatic logic [LIMIT_W-1:0] pick_limit();
        case ($urandom_range(0, 19))
            0: return '0;
            1: return '1;
            2: return MAX_SAMPLE;
            3: return LIMIT_RESET;
            4: return LIMIT_W'($urandom);
            default: return LIMIT_W'($urandom_range(1, 16));
        endcase
    endfunction

    // Builds one buffer from well-formed segments of a chosen flavor plus some noise.
    task automatic build_buffer();
        int flavor;
        int target;
        int seg;
        int r;
        int n;
        buf_bytes.delete();
        flavor = $urandom_range(0, 9);
        target = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
        while (buf_bytes.size() < target) begin
            r = $urandom_range(0, 99);
            if (flavor < 2) seg = (r < 90) ? SEG_ASCII : SEG_NOISE;
            else if (flavor < 5) seg = (r < 70) ? SEG_UTF8 : (r < 95) ? SEG_ASCII : SEG_NOISE;
            else if (flavor < 8) seg = (r < 70) ? SEG_EUC : (r < 95) ? SEG_ASCII : SEG_NOISE;
            else if (flavor == 8) seg = (r < 50) ? SEG_UTF8 : (r < 80) ? SEG_EUC : SEG_NOISE;
            else seg = SEG_NOISE;
            case (seg)
                SEG_ASCII: add_byte(8'($urandom_range(0, 127)));
                SEG_UTF8: begin
                    n = $urandom_range(1, 3);
                    case (n)
                        1: add_byte({3'b110, 5'($urandom)});
                        2: add_byte({4'b1110, 4'($urandom)});
                        default: add_byte({5'b11110, 3'($urandom)});
                    endcase
                    repeat (n) add_byte({2'b10, 6'($urandom)});
                end
                SEG_EUC: begin
                    add_byte({1'b1, 7'($urandom)});
                    add_byte({1'b1, 7'($urandom)});
                end
                default: add_byte(8'($urandom));
            endcase
        end
        // Cut the final sequence short now and then.
        if (buf_bytes.size() > 1 && $urandom_range(0, 5) == 0) void'(buf_bytes.pop_back());
    endtask

    initial begin
        logic     hit;
        t_verdict v;
        int       sent;
        int       nbuf;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: typed verdicts where obvious, the predictor elsewhere.
        for (int i = 0; i < DIR_ROWS; i++) begin
            if (DIR_TABLE[i].kind == ROW_LIMIT) begin
                drain();
                write_limit(DIR_TABLE[i].value);
            end else begin
                send_byte(DIR_TABLE[i].value[7:0], DIR_TABLE[i].last);
                sniff_byte(DIR_TABLE[i].value[7:0], DIR_TABLE[i].last, hit, v);
                if (DIR_TABLE[i].chk == CHK_GIVEN) queue_verdict(DIR_TABLE[i].want);
                else if (DIR_TABLE[i].chk == CHK_MODEL && hit) queue_verdict(v);
            end
        end

        // Random phases, each with its own limit and idling pattern.
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            drain();
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            write_limit(pick_limit());
            nbuf = $urandom_range(2, 8);
            repeat (nbuf) begin
                build_buffer();
                foreach (buf_bytes[k]) begin
                    feed_byte(buf_bytes[k], k == buf_bytes.size() - 1);
                    sent++;
                end
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (errors == 0 && verdicts_due.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
